FILE: rtl/multichannel_dc_blocking_filter_defines.svh
// assertion macros for the multichannel dc blocking filter
`ifndef MULTICHANNEL_DC_BLOCKING_FILTER_DEFINES_SVH
`define MULTICHANNEL_DC_BLOCKING_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DCBF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DCBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dcbf_pkg.sv
// shared types and constants for the multichannel dc blocking filter
`default_nettype none

package dcbf_pkg;

    localparam int MAX_CHANNELS_DEF = 4;
    localparam int NUM_COEFFS       = 4;
    localparam int SAMPLE_W         = 32;
    localparam int CHAN_W           = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int NUM_CH_W         = 3;
    localparam int FMT_W            = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CHANNELS  = 3'd0,
        REG_SAMPLE_FORMAT = 3'd1,
        REG_COEFF_CH0     = 3'd2,
        REG_COEFF_CH1     = 3'd3,
        REG_COEFF_CH2     = 3'd4,
        REG_COEFF_CH3     = 3'd5
    } reg_idx_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_16 = 2'd0,
        FMT_24 = 2'd1,
        FMT_32 = 2'd2
    } fmt_t;

    localparam logic [NUM_CH_W-1:0] NUM_CH_RESET = 3'd1;
    localparam logic [FMT_W-1:0]    FMT_RESET    = FMT_32;

    typedef struct packed {
        logic [NUM_CH_W-1:0]                    num_channels;
        logic [FMT_W-1:0]                       sample_format;
        logic [NUM_COEFFS-1:0][SAMPLE_W-1:0]    coeff;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/dcbf_if.sv
// valid/ready channels for input and result words
`default_nettype none

interface dcbf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dcbf_pkg::SAMPLE_W-1:0]  in_sample;
    logic                                  first_of_block;

    modport source (output valid, output in_sample, output first_of_block, input ready);
    modport sink   (input valid, input in_sample, input first_of_block, output ready);
endinterface

interface dcbf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dcbf_pkg::SAMPLE_W-1:0]  out_sample;
    logic [dcbf_pkg::CHAN_W-1:0]           out_channel;

    modport source (output valid, output out_sample, output out_channel, input ready);
    modport sink   (input valid, input out_sample, input out_channel, output ready);
endinterface

`default_nettype wire

FILE: rtl/dcbf_cfg_regs.sv
// configuration register file
`default_nettype none

module dcbf_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [dcbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dcbf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dcbf_pkg::cfg_t                           cfg
);

    dcbf_pkg::cfg_t cfg_reg;
    dcbf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (dcbf_pkg::reg_idx_t'(cfg_index))
                dcbf_pkg::REG_NUM_CHANNELS:
                    cfg_next.num_channels = cfg_data[dcbf_pkg::NUM_CH_W-1:0];
                dcbf_pkg::REG_SAMPLE_FORMAT:
                    cfg_next.sample_format = cfg_data[dcbf_pkg::FMT_W-1:0];
                dcbf_pkg::REG_COEFF_CH0: cfg_next.coeff[0] = cfg_data;
                dcbf_pkg::REG_COEFF_CH1: cfg_next.coeff[1] = cfg_data;
                dcbf_pkg::REG_COEFF_CH2: cfg_next.coeff[2] = cfg_data;
                dcbf_pkg::REG_COEFF_CH3: cfg_next.coeff[3] = cfg_data;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels  <= dcbf_pkg::NUM_CH_RESET;
            cfg_reg.sample_format <= dcbf_pkg::FMT_RESET;
            cfg_reg.coeff         <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/dcbf_filter_core.sv
// per-channel state and combinational filter datapath
`default_nettype none

module dcbf_filter_core #(
    parameter int MAX_CHANNELS = dcbf_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  dcbf_pkg::cfg_t                             cfg,
    input  wire logic                                  advance,
    input  wire logic signed [dcbf_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                                  first,
    output dcbf_pkg::res_t                             res
);

    localparam int W  = dcbf_pkg::SAMPLE_W;
    localparam int CW = dcbf_pkg::CHAN_W;
    localparam int NW = dcbf_pkg::NUM_CH_W;
    localparam logic [NW-1:0] MAX_CH = NW'(MAX_CHANNELS);

    logic [CW-1:0]        chan_idx_reg;
    logic [CW-1:0]        chan_idx_next;
    logic signed [W-1:0]  prev_in_reg  [MAX_CHANNELS];
    logic signed [W-1:0]  prev_out_reg [MAX_CHANNELS];

    logic [NW-1:0]        nch;
    logic [CW-1:0]        ch_raw;
    logic [CW-1:0]        ch;
    logic [NW-1:0]        ch_inc;
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  x_prev;
    logic signed [W-1:0]  y_prev;
    logic signed [W-1:0]  r;
    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] prod_rnd;
    logic signed [W+1:0]  fb;
    logic signed [W+3:0]  sum;
    logic signed [W-1:0]  y;
    logic signed [17:0]   r16;
    logic signed [25:0]   r24;
    logic signed [16:0]   q16;
    logic signed [24:0]   q24;
    logic signed [W-1:0]  out_val;

    // channel pick, with clamped channel count and stale index falling back to 0
    always_comb
    begin
        if (cfg.num_channels == '0)
            nch = NW'(1);
        else if (cfg.num_channels > MAX_CH)
            nch = MAX_CH;
        else
            nch = cfg.num_channels;

        ch_raw = first ? '0 : chan_idx_reg;
        ch     = ({1'b0, ch_raw} >= nch) ? '0 : ch_raw;
        ch_inc = {1'b0, ch} + NW'(1);
        chan_idx_next = (ch_inc == nch) ? '0 : ch_inc[CW-1:0];
    end

    // move narrow formats up to q1.31
    always_comb
    begin
        case (dcbf_pkg::fmt_t'(cfg.sample_format))
            dcbf_pkg::FMT_16: x = {sample[15:0], 16'b0};
            dcbf_pkg::FMT_24: x = {sample[23:0], 8'b0};
            default:          x = sample;
        endcase
    end

    always_comb
    begin
        x_prev = '0;
        y_prev = '0;
        r      = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (ch == CW'(i))
            begin
                x_prev = prev_in_reg[i];
                y_prev = prev_out_reg[i];
                r      = cfg.coeff[i];
            end
        end
    end

    // y = x - x_prev + round(r * y_prev >> 30), saturated to 32 bits
    always_comb
    begin
        prod     = r * y_prev;
        prod_rnd = prod + (2*W)'(64'sd1 <<< 29);
        fb       = prod_rnd[2*W-1:30];
        sum      = (W+4)'(x) - (W+4)'(x_prev) + (W+4)'(fb);
        if (sum[W+3:W-1] == '0 || sum[W+3:W-1] == '1)
            y = sum[W-1:0];
        else if (sum[W+3])
            y = {1'b1, {(W-1){1'b0}}};
        else
            y = {1'b0, {(W-1){1'b1}}};
    end

    // shift back with round-half-up and saturate to the format
    always_comb
    begin
        r16 = {y[W-1], y[W-1:15]} + 18'sd1;
        q16 = r16[17:1];
        r24 = {y[W-1], y[W-1:7]} + 26'sd1;
        q24 = r24[25:1];
        case (dcbf_pkg::fmt_t'(cfg.sample_format))
            dcbf_pkg::FMT_16:
            begin
                if (q16[16] == q16[15])
                    out_val = {{(W-16){q16[15]}}, q16[15:0]};
                else if (q16[16])
                    out_val = W'(-32'sd32768);
                else
                    out_val = W'(32'sd32767);
            end
            dcbf_pkg::FMT_24:
            begin
                if (q24[24] == q24[23])
                    out_val = {{(W-24){q24[23]}}, q24[23:0]};
                else if (q24[24])
                    out_val = W'(-32'sd8388608);
                else
                    out_val = W'(32'sd8388607);
            end
            default: out_val = y;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_idx_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            chan_idx_reg <= chan_idx_next;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                if (ch == CW'(i))
                begin
                    prev_in_reg[i]  <= x;
                    prev_out_reg[i] <= y;
                end
            end
        end
    end

    assign res.sample  = out_val;
    assign res.channel = ch;

endmodule

`default_nettype wire

FILE: rtl/multichannel_dc_blocking_filter.sv
// a word accepted into the input register passes the filter math into the result register,
// which drives the result port; one word per cycle, sustained while the result port is ready;
// a stalled result port holds one word in the input register and one in the result register
// before ready drops; feedback multiply, round and saturate are combinational and set the rate
// reset (rst_n, async low): config to defaults, channel rotation and history cleared
`default_nettype none

`include "multichannel_dc_blocking_filter_defines.svh"

module multichannel_dc_blocking_filter #(
    parameter int MAX_CHANNELS = dcbf_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    dcbf_in_if.sink                                  samples,
    dcbf_out_if.source                               results,
    input  wire logic                                cfg_we,
    input  wire logic [dcbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dcbf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int W = dcbf_pkg::SAMPLE_W;

    dcbf_pkg::cfg_t cfg;
    dcbf_pkg::res_t res;

    // input register stage
    logic                 s1_vld_reg;
    logic                 s1_vld_next;
    logic signed [W-1:0]  s1_sample_reg;
    logic                 s1_first_reg;

    // result register stage
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic signed [W-1:0]  out_sample_reg;
    logic [dcbf_pkg::CHAN_W-1:0] out_channel_reg;

    logic                 out_free;
    logic                 s1_adv;
    logic                 in_take;

    dcbf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // filter math sits between the input register and the result register;
    // channel history updates on the same edge the result is captured
    dcbf_filter_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (s1_adv),
        .sample  (s1_sample_reg),
        .first   (s1_first_reg),
        .res     (res)
    );

    // handshake: result slot frees when empty or drained this cycle,
    // the input slot frees when its word moves into the result slot
    always_comb
    begin
        out_free      = !out_vld_reg || results.ready;
        s1_adv        = s1_vld_reg && out_free;
        samples.ready = !s1_vld_reg || out_free;
        in_take       = samples.valid && samples.ready;

        if (in_take)
            s1_vld_next = 1'b1;
        else if (s1_adv)
            s1_vld_next = 1'b0;
        else
            s1_vld_next = s1_vld_reg;

        if (s1_adv)
            out_vld_next = 1'b1;
        else if (results.ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= samples.in_sample;
            s1_first_reg  <= samples.first_of_block;
        end
        if (s1_adv)
        begin
            out_sample_reg  <= res.sample;
            out_channel_reg <= res.channel;
        end
    end

    assign results.valid       = out_vld_reg;
    assign results.out_sample  = out_sample_reg;
    assign results.out_channel = out_channel_reg;

    // a result word only appears after a word sat in the input register
    `DCBF_ASSERT_SAME(a_out_from_s1, $rose(out_vld_reg), $past(s1_vld_reg), "result word without source word")
    // a word stuck behind a stalled result is not dropped
    `DCBF_ASSERT_NEXT(a_s1_held, s1_vld_reg && out_vld_reg && !results.ready, s1_vld_reg, "input word lost during stall")
    // first word of a block is always processed as channel 0
    `DCBF_ASSERT_NEXT(a_first_ch0, s1_adv && s1_first_reg, out_channel_reg == '0, "block start not on channel 0")

endmodule

`default_nettype wire
